@@ src/pfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pfc_pkg
// shared types and constants of the playfair digraph cipher
// ----------------------------------------------------------------------------
package pfc_pkg;

	localparam int           SIDE_W     = 3;      // width of the square side register
	localparam int           MIN_SIDE   = 5;      // smallest square side in use
	localparam logic [7:0]   PAD_LETTER = 8'h58;  // 'X'
	localparam int           CMD_DEPTH  = 4;      // command queue depth, power of two

	// configuration register indexes
	localparam logic [2:0] CFG_DECRYPT = 3'd0;
	localparam logic [2:0] CFG_SIDE    = 3'd1;
	localparam logic [2:0] CFG_CELLS0  = 3'd2;

	// what the back end is asked to do
	typedef enum logic [1:0] {
		CMD_PAIR,  // look up a digraph, two result beats
		CMD_LONE,  // unpaired decrypt letter, one beat with not_found
		CMD_MARK   // end marker with no letter, one beat
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] a;
		logic [7:0] b;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic [7:0] letter;
		logic       present;
		logic       nf;
		logic       last;
	} result_t;

endpackage

@@ src/pfc_front.sv @@
// ----------------------------------------------------------------------------
// pfc_front
// letter filter, x insertion and digraph pairing; issues back end commands
// ----------------------------------------------------------------------------
module pfc_front
	import pfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tlast,
	input  logic       dec,
	output logic       push_valid,
	output cmd_t       push_cmd,
	input  logic       fifo_full
);

	logic       held_v_q, prev_v_q, pend_v_q;
	logic [7:0] held_l_q, prev_l_q;
	cmd_t       pend_q;

	logic       s_acc, is_up, is_low, letter, ins;
	logic [7:0] up;
	logic       hv_n;
	logic [7:0] hl_n;
	logic [1:0] ncmd;
	cmd_t       c0, c1;

	assign s_tready = !pend_v_q && !fifo_full;
	assign s_acc    = s_tvalid && s_tready;

	always_comb begin
		is_up  = s_tdata inside {[8'h41:8'h5A]};
		is_low = s_tdata inside {[8'h61:8'h7A]};
		letter = is_up || is_low;
		up     = is_low ? (s_tdata - 8'h20) : s_tdata;
		ins    = !dec && letter && prev_v_q && (prev_l_q == up);

		hv_n = held_v_q;
		hl_n = held_l_q;
		ncmd = 2'd0;
		c0   = '0;
		c1   = '0;

		// inserted x between equal letters
		if (ins) begin
			if (hv_n) begin
				c0   = '{kind: CMD_PAIR, a: hl_n, b: PAD_LETTER, last: 1'b0};
				ncmd = 2'd1;
				hv_n = 1'b0;
			end else begin
				hl_n = PAD_LETTER;
				hv_n = 1'b1;
			end
		end

		// the letter itself
		if (letter) begin
			if (hv_n) begin
				if (ncmd == 2'd0) begin
					c0 = '{kind: CMD_PAIR, a: hl_n, b: up, last: 1'b0};
				end else begin
					c1 = '{kind: CMD_PAIR, a: hl_n, b: up, last: 1'b0};
				end
				ncmd = ncmd + 2'd1;
				hv_n = 1'b0;
			end else begin
				hl_n = up;
				hv_n = 1'b1;
			end
		end

		// message end: flush the held letter, or send a bare marker
		if (s_tlast) begin
			if (hv_n) begin
				if (ncmd == 2'd0) begin
					c0 = dec ? cmd_t'{kind: CMD_LONE, a: hl_n, b: 8'h00, last: 1'b0}
					         : cmd_t'{kind: CMD_PAIR, a: hl_n, b: PAD_LETTER, last: 1'b0};
				end else begin
					c1 = dec ? cmd_t'{kind: CMD_LONE, a: hl_n, b: 8'h00, last: 1'b0}
					         : cmd_t'{kind: CMD_PAIR, a: hl_n, b: PAD_LETTER, last: 1'b0};
				end
				ncmd = ncmd + 2'd1;
				hv_n = 1'b0;
			end
			if (ncmd == 2'd0) begin
				c0   = '{kind: CMD_MARK, a: 8'h00, b: 8'h00, last: 1'b0};
				ncmd = 2'd1;
			end
			if (ncmd == 2'd1) begin
				c0.last = 1'b1;
			end else begin
				c1.last = 1'b1;
			end
		end
	end

	always_comb begin
		push_valid = 1'b0;
		push_cmd   = c0;
		if (pend_v_q) begin
			push_valid = !fifo_full;
			push_cmd   = pend_q;
		end else if (s_acc && ncmd != 2'd0) begin
			push_valid = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
			held_l_q <= 8'h00;
			prev_v_q <= 1'b0;
			prev_l_q <= 8'h00;
			pend_v_q <= 1'b0;
		end else begin
			if (pend_v_q && !fifo_full) begin
				pend_v_q <= 1'b0;
			end
			if (s_acc) begin
				if (ncmd == 2'd2) begin
					pend_v_q <= 1'b1;
				end
				if (s_tlast) begin
					held_v_q <= 1'b0;
					held_l_q <= 8'h00;
					prev_v_q <= 1'b0;
					prev_l_q <= 8'h00;
				end else begin
					held_v_q <= hv_n;
					held_l_q <= hl_n;
					if (letter) begin
						prev_v_q <= 1'b1;
						prev_l_q <= up;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc && ncmd == 2'd2) begin
			pend_q <= c1;
		end
	end

	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		s_acc && s_tlast |=> !held_v_q && !prev_v_q)
		else $error("pairing state not cleared after message end");

endmodule

@@ src/pfc_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// pfc_cmd_fifo
// short command queue between the pairing front end and the lookup back end
// ----------------------------------------------------------------------------
module pfc_cmd_fifo
	import pfc_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	localparam int PW = $clog2(CMD_DEPTH);

	cmd_t          mem_q [CMD_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [PW:0]   cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == (PW+1)'(CMD_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("command pushed into a full queue");

endmodule

@@ src/pfc_back.sv @@
// ----------------------------------------------------------------------------
// pfc_back
// square lookup and digraph substitution, two-slot result buffer
// ----------------------------------------------------------------------------
module pfc_back
	import pfc_pkg::*;
#(
	parameter int MAX_SIDE = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              dec,
	input  logic [SIDE_W-1:0] side,
	input  logic [7:0]        cells [MAX_SIDE*MAX_SIDE],
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	localparam int IW = $clog2(MAX_SIDE);

	function automatic logic [IW-1:0] nxt(input logic [IW-1:0] x,
	                                     input logic [SIDE_W-1:0] n, input logic d);
		logic [IW-1:0] top_i;
		top_i = IW'(n - SIDE_W'(1));
		if (d) begin
			nxt = (x == '0) ? top_i : x - IW'(1);
		end else begin
			nxt = (x == top_i) ? '0 : x + IW'(1);
		end
	endfunction

	// stage 1: command being searched
	logic          v1_q;
	cmd_t          cmd_s1;
	logic          fa, fb;
	logic [IW-1:0] ra, ca, rb, cb;

	// stage 2: positions found, substitution
	logic          v2_q;
	cmd_t          cmd_s2;
	logic          fa_s2, fb_s2;
	logic [IW-1:0] ra_s2, ca_s2, rb_s2, cb_s2;
	logic [IW-1:0] t0r, t0c, t1r, t1c;
	logic [7:0]    l0, l1;
	result_t       r0, r1;
	logic [1:0]    rcnt;

	// result buffer
	result_t       ob_q [2];
	logic [1:0]    ob_rem_q;
	logic          ob_sel_q;
	result_t       cur;

	logic m_acc, ob_load, adv1;

	assign cur      = ob_q[ob_sel_q];
	assign m_tvalid = (ob_rem_q != 2'd0);
	assign m_tdata  = cur.letter;
	assign m_tuser  = {cur.nf, cur.present};
	assign m_tlast  = cur.last;
	assign m_acc    = m_tvalid && m_tready;
	assign ob_load  = v2_q && (ob_rem_q == 2'd0 || (ob_rem_q == 2'd1 && m_acc));
	assign adv1     = v1_q && (!v2_q || ob_load);
	assign cmd_pop  = cmd_valid && (!v1_q || adv1);

	// first match in row-major order wins: scan backwards, last hit stays
	always_comb begin
		fa = 1'b0; ra = '0; ca = '0;
		fb = 1'b0; rb = '0; cb = '0;
		for (int nn = MIN_SIDE; nn <= MAX_SIDE; nn++) begin
			if (side == SIDE_W'(nn)) begin
				for (int i = nn - 1; i >= 0; i--) begin
					for (int j = nn - 1; j >= 0; j--) begin
						if (cells[i*nn+j] == cmd_s1.a) begin
							fa = 1'b1; ra = IW'(i); ca = IW'(j);
						end
						if (cells[i*nn+j] == cmd_s1.b) begin
							fb = 1'b1; rb = IW'(i); cb = IW'(j);
						end
					end
				end
			end
		end
	end

	always_comb begin
		if (ra_s2 == rb_s2) begin
			t0r = ra_s2; t0c = nxt(ca_s2, side, dec);
			t1r = rb_s2; t1c = nxt(cb_s2, side, dec);
		end else if (ca_s2 == cb_s2) begin
			t0r = nxt(ra_s2, side, dec); t0c = ca_s2;
			t1r = nxt(rb_s2, side, dec); t1c = cb_s2;
		end else begin
			t0r = ra_s2; t0c = cb_s2;
			t1r = rb_s2; t1c = ca_s2;
		end
		l0 = 8'h00;
		l1 = 8'h00;
		for (int nn = MIN_SIDE; nn <= MAX_SIDE; nn++) begin
			if (side == SIDE_W'(nn)) begin
				for (int i = 0; i < nn; i++) begin
					for (int j = 0; j < nn; j++) begin
						if (t0r == IW'(i) && t0c == IW'(j)) begin
							l0 = cells[i*nn+j];
						end
						if (t1r == IW'(i) && t1c == IW'(j)) begin
							l1 = cells[i*nn+j];
						end
					end
				end
			end
		end
	end

	always_comb begin
		r0   = '0;
		r1   = '0;
		rcnt = 2'd1;
		case (cmd_s2.kind)
			CMD_PAIR: begin
				rcnt = 2'd2;
				if (fa_s2 && fb_s2) begin
					r0 = '{letter: l0, present: 1'b1, nf: 1'b0, last: 1'b0};
					r1 = '{letter: l1, present: 1'b1, nf: 1'b0, last: cmd_s2.last};
				end else begin
					r0 = '{letter: cmd_s2.a, present: 1'b1, nf: 1'b1, last: 1'b0};
					r1 = '{letter: cmd_s2.b, present: 1'b1, nf: 1'b1, last: cmd_s2.last};
				end
			end
			CMD_LONE: begin
				r0 = '{letter: cmd_s2.a, present: 1'b1, nf: 1'b1, last: cmd_s2.last};
			end
			default: begin
				r0 = '{letter: 8'h00, present: 1'b0, nf: 1'b0, last: cmd_s2.last};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q     <= 1'b0;
			v2_q     <= 1'b0;
			ob_rem_q <= 2'd0;
			ob_sel_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				v1_q <= 1'b1;
			end else if (adv1) begin
				v1_q <= 1'b0;
			end
			if (adv1) begin
				v2_q <= 1'b1;
			end else if (ob_load) begin
				v2_q <= 1'b0;
			end
			if (ob_load) begin
				ob_rem_q <= rcnt;
				ob_sel_q <= 1'b0;
			end else if (m_acc) begin
				ob_rem_q <= ob_rem_q - 2'd1;
				ob_sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
		end
		if (adv1) begin
			cmd_s2 <= cmd_s1;
			fa_s2  <= fa;
			ra_s2  <= ra;
			ca_s2  <= ca;
			fb_s2  <= fb;
			rb_s2  <= rb;
			cb_s2  <= cb;
		end
		if (ob_load) begin
			ob_q[0] <= r0;
			ob_q[1] <= r1;
		end
	end

	a_pair_head_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		ob_rem_q == 2'd2 |-> !m_tlast && m_tuser[0])
		else $error("first beat of a digraph flagged last or empty");

	a_marker_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tlast && !m_tuser[1] && m_tdata == 8'h00)
		else $error("malformed end marker beat");

endmodule

@@ src/playfair_digraph_cipher_top.sv @@
// ----------------------------------------------------------------------------
// playfair_digraph_cipher_top
// streaming playfair cipher over a loadable 5x5 or 6x6 letter square
// ----------------------------------------------------------------------------
// Raw message bytes enter on the s_ stream, one byte per beat, with s_tlast on
// the final byte of a message. Non-letters are dropped and letters uppercased;
// in encrypt mode an X goes between equal neighbours and an odd tail is padded
// with X. Each digraph comes out as two beats on the m_ stream; a digraph with
// a letter not found in the square passes through unchanged with not_found
// set on both beats, as does a lone final letter in decrypt mode. A message
// that yields no letter gives one marker beat with letter_present low and
// m_tlast high. The front end holds off bytes while the command queue is full
// or the second of two digraphs from one byte waits to be queued; the back end
// looks a digraph up through a two-stage search/substitute pipeline and emits
// one result beat per cycle while m_tready is high. The square and the mode
// are to be loaded over the cfg_ channel by the user only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
module playfair_digraph_cipher_top
	import pfc_pkg::*;
#(
	parameter int MAX_SIDE = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] text_byte
	input  logic        s_tlast,   // end_of_message
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] cipher_letter
	output logic [1:0]  m_tuser,   // [0] letter_present, [1] not_found
	output logic        m_tlast,   // last_of_message
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int NCELL = MAX_SIDE * MAX_SIDE;

	logic              decrypt_q;
	logic [SIDE_W-1:0] side_q, side_eff;
	logic [7:0]        cells_q [NCELL];
	logic              cfg_acc;

	logic push_valid, fifo_full, cmd_valid, cmd_pop;
	cmd_t push_cmd, head_cmd;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// out-of-range sides clamp to the nearest legal one
	assign side_eff = (side_q < SIDE_W'(MIN_SIDE)) ? SIDE_W'(MIN_SIDE) :
	                  (side_q > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decrypt_q <= 1'b0;
			side_q    <= SIDE_W'(MIN_SIDE);
			for (int k = 0; k < NCELL; k++) begin
				cells_q[k] <= 8'h00;
			end
		end else if (cfg_acc) begin
			if (cfg_index == CFG_DECRYPT) begin
				decrypt_q <= cfg_data[0];
			end
			if (cfg_index == CFG_SIDE) begin
				side_q <= cfg_data[SIDE_W-1:0];
			end
			// eight cells per register, lowest cell in the low byte
			for (int k = 0; k < NCELL; k++) begin
				if (cfg_index == 3'(CFG_CELLS0 + (k >> 3))) begin
					cells_q[k] <= cfg_data[(k & 7)*8 +: 8];
				end
			end
		end
	end

	pfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.dec        (decrypt_q),
		.push_valid (push_valid),
		.push_cmd   (push_cmd),
		.fifo_full  (fifo_full)
	);

	pfc_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_valid),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (cmd_pop),
		.valid    (cmd_valid),
		.head     (head_cmd)
	);

	pfc_back #(
		.MAX_SIDE (MAX_SIDE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec       (decrypt_q),
		.side      (side_eff),
		.cells     (cells_q),
		.cmd_valid (cmd_valid),
		.cmd       (head_cmd),
		.cmd_pop   (cmd_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

@@ dv/pfc_checker.sv @@
// ----------------------------------------------------------------------------
// pfc_checker
// predicts and checks the result beats of the playfair digraph cipher
// ----------------------------------------------------------------------------
// Watches the cfg_, s_ and m_ channels. Keeps its own copy of the mode, the
// side and the square, and of the held and previous letters. Every accepted
// text beat is turned into the result beats it causes, queued in order. Each
// accepted result beat is compared field by field against the oldest one.
module pfc_checker
	import pfc_pkg::*;
#(
	parameter int MAX_SIDE = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          mismatches,
	output int          beats_due
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CFG_CELLS4 = CFG_CELLS0 + 3'd4;

	logic              dec_mode;
	logic [SIDE_W-1:0] side_reg;
	logic [63:0]       cells [5];
	logic [7:0]        held_letter;
	logic              held_v;
	logic [7:0]        prev_letter;
	logic              prev_v;

	result_t due_beats [$];
	result_t step_buf [4];
	int      step_n;
	result_t want;

	function automatic int side_in_use();
		int s;
		s = side_reg;
		if (s < MIN_SIDE) s = MIN_SIDE;
		if (s > MAX_SIDE) s = MAX_SIDE;
		return s;
	endfunction

	function automatic logic [7:0] cell_byte(input int k);
		logic [63:0] w;
		w = cells[(k >> 3) % 5];
		return w[(k & 7) * 8 +: 8];
	endfunction

	// first match in row-major order wins
	function automatic bit find_cell(input logic [7:0] c, input int n,
		output int row, output int col);
		row = 0;
		col = 0;
		for (int i = 0; i < n; i++)
			for (int j = 0; j < n; j++)
				if (cell_byte(i * n + j) == c) begin
					row = i;
					col = j;
					return 1'b1;
				end
		return 1'b0;
	endfunction

	task automatic queue_beat(input logic [7:0] l, input logic p, input logic f);
		step_buf[step_n] = '{letter: l, present: p, nf: f, last: 1'b0};
		step_n++;
	endtask

	task automatic encode_pair(input logic [7:0] a, input logic [7:0] b);
		int n, shift, ra, ca, rb, cb;
		bit fa, fb;
		n     = side_in_use();
		shift = dec_mode ? n - 1 : 1;
		fa    = find_cell(a, n, ra, ca);
		fb    = find_cell(b, n, rb, cb);
		if (!fa || !fb) begin
			queue_beat(a, 1'b1, 1'b1);
			queue_beat(b, 1'b1, 1'b1);
		end else if (ra == rb) begin
			queue_beat(cell_byte(ra * n + (ca + shift) % n), 1'b1, 1'b0);
			queue_beat(cell_byte(rb * n + (cb + shift) % n), 1'b1, 1'b0);
		end else if (ca == cb) begin
			queue_beat(cell_byte(((ra + shift) % n) * n + ca), 1'b1, 1'b0);
			queue_beat(cell_byte(((rb + shift) % n) * n + cb), 1'b1, 1'b0);
		end else begin
			queue_beat(cell_byte(ra * n + cb), 1'b1, 1'b0);
			queue_beat(cell_byte(rb * n + ca), 1'b1, 1'b0);
		end
	endtask

	task automatic pair_up(input logic [7:0] c);
		if (held_v) begin
			held_v = 1'b0;
			encode_pair(held_letter, c);
		end else begin
			held_letter = c;
			held_v      = 1'b1;
		end
	endtask

	task automatic digest_byte(input logic [7:0] b, input logic eom);
		logic [7:0] up;
		bit         is_letter;
		step_n    = 0;
		is_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
		if (is_letter) begin
			up = b & 8'hDF;
			if (!dec_mode && prev_v && prev_letter == up)
				pair_up(PAD_LETTER);
			pair_up(up);
			prev_letter = up;
			prev_v      = 1'b1;
		end
		if (eom) begin
			if (held_v) begin
				if (dec_mode) begin
					held_v = 1'b0;
					queue_beat(held_letter, 1'b1, 1'b1);
				end else begin
					pair_up(PAD_LETTER);
				end
			end
			if (step_n == 0)
				queue_beat(8'h00, 1'b0, 1'b0);
			step_buf[step_n - 1].last = 1'b1;
			held_letter = 8'h00;
			held_v      = 1'b0;
			prev_letter = 8'h00;
			prev_v      = 1'b0;
		end
		for (int i = 0; i < step_n; i++)
			due_beats.push_back(step_buf[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dec_mode    = 1'b0;
			side_reg    = SIDE_W'(MIN_SIDE);
			for (int r = 0; r < 5; r++)
				cells[r] = 64'h0;
			held_letter = 8'h00;
			held_v      = 1'b0;
			prev_letter = 8'h00;
			prev_v      = 1'b0;
			due_beats.delete();
			beats_due   = 0;
			mismatches  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DECRYPT: dec_mode = cfg_data[0];
					CFG_SIDE:    side_reg = cfg_data[SIDE_W-1:0];
					CFG_CELLS4:  cells[4] = {32'h0, cfg_data[31:0]};
					default: begin
						if (cfg_index >= CFG_CELLS0 && cfg_index < CFG_CELLS4)
							cells[cfg_index - CFG_CELLS0] = cfg_data;
					end
				endcase
			end
			if (s_tvalid && s_tready)
				digest_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				// fields shown as letter/present/nf/last
				if (due_beats.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat, got %h/%b/%b/%b",
						$time, m_tdata, m_tuser[0], m_tuser[1], m_tlast);
				end else begin
					want = due_beats.pop_front();
					if (m_tdata !== want.letter || m_tuser[0] !== want.present ||
						m_tuser[1] !== want.nf || m_tlast !== want.last) begin
						mismatches++;
						$display("%0t: mismatch, want %h/%b/%b/%b got %h/%b/%b/%b",
							$time, want.letter, want.present, want.nf, want.last,
							m_tdata, m_tuser[0], m_tuser[1], m_tlast);
					end
				end
			end
			beats_due = due_beats.size();
		end
	end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// stream testbench for the playfair digraph cipher
// ----------------------------------------------------------------------------
// Drives text beats and configuration writes into the block; the checker
// beside it predicts every result beat and compares. A short directed part
// hits the byte class borders, X insertion and padding, letters missing from
// the square, equal letters in one digraph, a lone decrypt letter and the
// bare end marker. Random messages follow under six settings of mode, side
// (out-of-range sides included) and square contents, with three idling mixes
// on the two stream sides, a long receiver hold-off and a full drain pause.
module tb_top
	import pfc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int         BLOCK_MAX_SIDE = 6;
	localparam int         LAT_CYCLES     = 12;     // settle time after the last beat
	localparam int         HOLD_CYCLES    = 150;    // long receiver hold-off
	localparam int         SEG_ITEMS      = 38;     // random text beats per setting
	localparam logic [2:0] CFG_UNUSED     = 3'd7;   // no register behind this index

	typedef enum int {
		SQ_ALPHA5,  // 25 letters without J, shuffled
		SQ_ALPHA6,  // 26 letters and ten digits, shuffled
		SQ_DUP5,    // 5x5 letters with one cell duplicated
		SQ_NOISE    // random bytes
	} square_kind_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = 3'd0;
	logic [63:0] cfg_data  = 64'h0;

	int mismatches;
	int beats_due;

	// idling mix, in percent of cycles
	int snd_idle_pct = 19;
	int rcv_idle_pct = 47;

	// long hold-off requests, served by the receiver process
	int hold_req_n = 0;
	int hold_seen  = 0;
	int hold_left  = 0;

	// last letter sent, uppercased, to build runs of equal letters
	logic [7:0] last_up = 8'h00;

	playfair_digraph_cipher_top #(
		.MAX_SIDE(BLOCK_MAX_SIDE)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),    // [7:0] text_byte
		.s_tlast  (s_tlast),    // end_of_message
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),    // [7:0] cipher_letter
		.m_tuser  (m_tuser),    // [0] letter_present, [1] not_found
		.m_tlast  (m_tlast),    // last_of_message
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pfc_checker #(
		.MAX_SIDE(BLOCK_MAX_SIDE)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.beats_due (beats_due)
	);

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// receiver: random back-pressure, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_req_n != hold_seen) begin
			hold_seen = hold_req_n;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// sender idles between beats; every low valid is followed by an edge
	task automatic idle_gap();
		while ($urandom_range(99) < snd_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// offer one text beat and return at the edge that takes it
	task automatic send_byte(input logic [7:0] b, input logic eom);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eom;
		do @(posedge clk); while (!s_tready);
	endtask

	// one message, end marked on its last character
	task automatic send_string(input string txt);
		for (int k = 0; k < txt.len(); k++) begin
			idle_gap();
			send_byte(txt[k], k == txt.len() - 1);
		end
	endtask

	// stop offering until every predicted beat has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (beats_due != 0);
	endtask

	// drained and settled, safe for register writes
	task automatic quiesce();
		drain_results();
		repeat (LAT_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// build a square cell by cell, then write all five cell registers
	task automatic load_square(input square_kind_t kind);
		logic [7:0]  sym [36];
		logic [7:0]  t;
		logic [63:0] w;
		int          cnt, j, k;
		for (k = 0; k < 36; k++)
			sym[k] = 8'($urandom_range(255));
		cnt = 0;
		if (kind == SQ_ALPHA5 || kind == SQ_DUP5) begin
			for (k = 0; k < 26; k++)
				if ("A" + k != "J") begin
					sym[cnt] = 8'("A" + k);
					cnt++;
				end
		end else if (kind == SQ_ALPHA6) begin
			for (k = 0; k < 26; k++)
				sym[k] = 8'("A" + k);
			for (k = 0; k < 10; k++)
				sym[26 + k] = 8'("0" + k);
			cnt = 36;
		end
		for (k = cnt - 1; k > 0; k--) begin
			j      = $urandom_range(k);
			t      = sym[k];
			sym[k] = sym[j];
			sym[j] = t;
		end
		// a later copy of an earlier cell; the earlier one must win
		if (kind == SQ_DUP5)
			sym[$urandom_range(24, 13)] = sym[$urandom_range(12)];
		for (int r = 0; r < 5; r++) begin
			w = {$urandom, $urandom};
			for (int c = 0; c < 8; c++)
				if (r * 8 + c < 36)
					w[c * 8 +: 8] = sym[r * 8 + c];
			write_reg(CFG_CELLS0 + 3'(r), w);
		end
	endtask

	// mode and side carry random upper bits that the block must ignore
	task automatic configure(input logic dec, input logic [SIDE_W-1:0] side,
		input square_kind_t kind);
		logic [63:0] w;
		w = {$urandom, $urandom};
		w[0] = dec;
		write_reg(CFG_DECRYPT, w);
		w = {$urandom, $urandom};
		w[SIDE_W-1:0] = side;
		write_reg(CFG_SIDE, w);
		load_square(kind);
	endtask

	// mostly letters in both cases with runs of equal ones, some noise bytes
	function automatic logic [7:0] next_text_byte();
		int         pick;
		logic [7:0] b;
		pick = $urandom_range(99);
		if (pick < 12 && last_up != 8'h00)
			b = last_up | ($urandom_range(1) ? 8'h20 : 8'h00);
		else if (pick < 62)
			b = 8'("A" + $urandom_range(25));
		else if (pick < 82)
			b = 8'("a" + $urandom_range(25));
		else
			b = 8'($urandom_range(255));
		if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
			last_up = b & 8'hDF;
		return b;
	endfunction

	// random messages; the last beat always closes the message
	task automatic run_messages(input int count, input bit pressure);
		logic eom;
		for (int i = 0; i < count; i++) begin
			idle_gap();
			if (pressure && i == 4)
				hold_req_n++;              // receiver stalls, block fills up
			if (pressure && i == count - 10)
				drain_results();           // sender waits out every result
			eom = (i == count - 1) || ($urandom_range(9) == 0);
			send_byte(next_text_byte(), eom);
		end
	endtask

	initial begin
		logic [7:0] border_bytes [8];
		border_bytes = '{8'h00, "a", 8'h40, 8'h5B, "z", 8'h60, 8'h7B, 8'hFF};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset square holds only zero bytes: nothing is found
		send_string("AB");
		quiesce();

		configure(1'b0, SIDE_W'(5), SQ_ALPHA5);
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		send_string("HELLO");              // X between the equal letters
		// class borders around the letter ranges; ends with a bare marker
		for (int k = 0; k < 8; k++) begin
			idle_gap();
			send_byte(border_bytes[k], k == 7);
		end
		send_string("JZ");                 // J is not in the 5x5 square
		send_string("Q");                  // odd tail padded with X
		send_string("XX");                 // X against X, twice
		quiesce();

		write_reg(CFG_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFF);
		send_string("AAB");                // equal pair, then a lone letter
		idle_gap();
		send_byte(8'h20, 1'b1);            // message with no letter at all
		quiesce();

		// sender light, receiver heavy
		configure(1'b0, SIDE_W'(5), SQ_ALPHA5);
		run_messages(SEG_ITEMS, 1'b0);
		quiesce();
		configure(1'b1, SIDE_W'(6), SQ_ALPHA6);
		run_messages(SEG_ITEMS, 1'b1);
		quiesce();

		// sender heavy, receiver light
		snd_idle_pct = 47;
		rcv_idle_pct = 19;
		configure(1'b0, SIDE_W'(0), SQ_DUP5);      // side below range
		run_messages(SEG_ITEMS, 1'b0);
		quiesce();
		configure(1'b1, SIDE_W'(7), SQ_NOISE);     // side above range
		run_messages(SEG_ITEMS, 1'b0);
		quiesce();

		// no idling on either side
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		configure(1'b0, SIDE_W'(6), SQ_ALPHA6);
		run_messages(SEG_ITEMS, 1'b1);
		quiesce();
		configure(1'b1, SIDE_W'(4), SQ_ALPHA5);
		write_reg(CFG_UNUSED, {$urandom, $urandom});
		run_messages(SEG_ITEMS, 1'b0);
		quiesce();

		if (mismatches == 0 && beats_due == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	// run limit, far beyond the slowest correct run
	initial begin
		#4_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule

@@ filelist.f @@
src/pfc_pkg.sv
src/pfc_front.sv
src/pfc_cmd_fifo.sv
src/pfc_back.sv
src/playfair_digraph_cipher_top.sv
dv/pfc_checker.sv
dv/tb_top.sv
